>>> sv/gblr_pkg.sv
package gblr_pkg;

    localparam int COORD_BITS = 6;
    localparam int DEPTH_BITS = 16;
    localparam int COLOR_BITS = 8;
    localparam int DIST_BITS  = 2 * COORD_BITS + 1;
    localparam int QUOT_BITS  = 16;
    localparam int V8_BITS    = 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_DIST,
        S_DIV,
        S_SQRT,
        S_BLEND,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        CH_DEPTH,
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } t_chan;

endpackage

>>> sv/gradient_line_rasterizer_core.sv
// Channel | Direction | Handshake                  | Word
// line    | in        | i_in_valid / o_in_ready    | endpoints, depths, colors
// pixel   | out       | o_out_valid / i_out_ready  | x, y, depth, rgb, last flag
//
// Each pixel passes through the squared distance, the restoring divider, the square
// root, the one shared blend multiplier (one channel at a time) and the output
// register, where it waits out any output stall. A line first passes a setup
// state; a zero-length line returns from setup to idle and emits no pixels.
// Reset is synchronous and active low; no line is accepted until all its
// pixels are taken. An output stall holds the whole sequencer.
module gradient_line_rasterizer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [5:0]  i_start_x,
    input  logic [5:0]  i_start_y,
    input  logic [5:0]  i_end_x,
    input  logic [5:0]  i_end_y,
    input  logic [15:0] i_start_depth,
    input  logic [15:0] i_end_depth,
    input  logic [7:0]  i_start_red,
    input  logic [7:0]  i_start_green,
    input  logic [7:0]  i_start_blue,
    input  logic [7:0]  i_end_red,
    input  logic [7:0]  i_end_green,
    input  logic [7:0]  i_end_blue,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_pixel_x,
    output logic [5:0]  o_pixel_y,
    output logic [15:0] o_pixel_depth,
    output logic [7:0]  o_pixel_red,
    output logic [7:0]  o_pixel_green,
    output logic [7:0]  o_pixel_blue,
    output logic        o_last_pixel
);

    localparam int CB = gblr_pkg::COORD_BITS;
    localparam int DB = gblr_pkg::DIST_BITS;
    localparam int QB = gblr_pkg::QUOT_BITS;

    gblr_pkg::t_state r_state, n_state;

    logic [CB-1:0] r_sx, r_sy, r_x, r_y, n_x, n_y;
    logic [15:0]   r_sd, r_ed;
    logic [7:0]    r_sr, r_sg, r_sb, r_er, r_eg, r_eb;
    logic [CB-1:0] r_adx, r_ady, r_steps, n_steps;
    logic          r_xmaj, r_negx, r_negy;
    logic signed [8:0] r_err, n_err;
    logic [DB-1:0] r_dt2, n_dt2, r_rem, n_rem;
    logic [QB-1:0] r_q, n_q, r_sv, n_sv, r_sr2, n_sr2, r_sbit, n_sbit;
    logic [3:0]    r_cnt, n_cnt;
    logic [7:0]    r_v8, n_v8;
    gblr_pkg::t_chan r_ch, n_ch;
    logic [15:0]   r_pd, n_pd;
    logic [7:0]    r_pr, r_pg, r_pb, n_pr, n_pg, n_pb;

    logic signed [CB:0] a_dx, a_dy, p_dx, p_dy;
    logic [CB-1:0] a_adx, a_ady, a_major, a_minor, p_ax, p_ay, major, minor;
    logic          a_xmaj;
    logic [DB:0]   div_t;
    logic [QB:0]   sq_t;
    logic [15:0]   bl_a, bl_b, bl_res;
    logic signed [16:0] bl_diff;
    logic signed [26:0] bl_sum;
    logic          in_acc, out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    assign a_dx   = $signed({1'b0, i_end_x}) - $signed({1'b0, i_start_x});
    assign a_dy   = $signed({1'b0, i_end_y}) - $signed({1'b0, i_start_y});
    assign a_adx  = a_dx[CB] ? CB'(-a_dx) : a_dx[CB-1:0];
    assign a_ady  = a_dy[CB] ? CB'(-a_dy) : a_dy[CB-1:0];
    assign a_xmaj = a_ady < a_adx;
    assign a_major = a_xmaj ? a_adx : a_ady;
    assign a_minor = a_xmaj ? a_ady : a_adx;

    assign major = r_xmaj ? r_adx : r_ady;
    assign minor = r_xmaj ? r_ady : r_adx;

    assign p_dx = $signed({1'b0, r_x}) - $signed({1'b0, r_sx});
    assign p_dy = $signed({1'b0, r_y}) - $signed({1'b0, r_sy});
    assign p_ax = p_dx[CB] ? CB'(-p_dx) : p_dx[CB-1:0];
    assign p_ay = p_dy[CB] ? CB'(-p_dy) : p_dy[CB-1:0];

    assign div_t = {r_rem, 1'b0};
    assign sq_t  = {1'b0, r_sr2} + {1'b0, r_sbit};

    always_comb begin
        unique case (r_ch)
            gblr_pkg::CH_DEPTH: begin bl_a = r_sd;         bl_b = r_ed;         end
            gblr_pkg::CH_RED:   begin bl_a = {8'd0, r_sr}; bl_b = {8'd0, r_er}; end
            gblr_pkg::CH_GREEN: begin bl_a = {8'd0, r_sg}; bl_b = {8'd0, r_eg}; end
            gblr_pkg::CH_BLUE:  begin bl_a = {8'd0, r_sb}; bl_b = {8'd0, r_eb}; end
            default:            begin bl_a = r_sd;         bl_b = r_ed;         end
        endcase
    end

    assign bl_diff = $signed({1'b0, bl_b}) - $signed({1'b0, bl_a});
    assign bl_sum  = $signed({3'b000, bl_a, 8'd0})
                   + 27'(bl_diff * $signed({1'b0, r_v8}))
                   + 27'sd128;
    assign bl_res  = bl_sum[23:8];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gblr_pkg::S_IDLE:  if (in_acc) n_state = gblr_pkg::S_SETUP;
            gblr_pkg::S_SETUP: n_state = (r_steps == '0) ? gblr_pkg::S_IDLE
                                                         : gblr_pkg::S_DIST;
            gblr_pkg::S_DIST:  n_state = gblr_pkg::S_DIV;
            gblr_pkg::S_DIV:   if (r_cnt == '0) n_state = gblr_pkg::S_SQRT;
            gblr_pkg::S_SQRT:  if (r_sbit[0]) n_state = gblr_pkg::S_BLEND;
            gblr_pkg::S_BLEND: if (r_ch == gblr_pkg::CH_BLUE) n_state = gblr_pkg::S_OUT;
            gblr_pkg::S_OUT: begin
                if (out_acc) begin
                    n_state = (r_steps == CB'(1)) ? gblr_pkg::S_IDLE : gblr_pkg::S_DIST;
                end
            end
            default: n_state = gblr_pkg::S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_x = r_x; n_y = r_y; n_err = r_err; n_steps = r_steps;
        n_dt2 = r_dt2; n_rem = r_rem; n_q = r_q; n_cnt = r_cnt;
        n_sv = r_sv; n_sr2 = r_sr2; n_sbit = r_sbit; n_v8 = r_v8;
        n_ch = r_ch; n_pd = r_pd; n_pr = r_pr; n_pg = r_pg; n_pb = r_pb;
        unique case (r_state)
            gblr_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_x     = i_start_x;
                    n_y     = i_start_y;
                    n_steps = a_major;
                    n_err   = $signed({2'b00, a_minor, 1'b0}) - $signed({3'b000, a_major});
                end
            end
            gblr_pkg::S_SETUP: begin
                n_dt2 = DB'({6'd0, r_adx} * {6'd0, r_adx}) + DB'({6'd0, r_ady} * {6'd0, r_ady});
            end
            gblr_pkg::S_DIST: begin
                n_rem = DB'({6'd0, p_ax} * {6'd0, p_ax}) + DB'({6'd0, p_ay} * {6'd0, p_ay});
                n_q   = '0;
                n_cnt = 4'(QB - 1);
            end
            gblr_pkg::S_DIV: begin
                if (div_t >= {1'b0, r_dt2}) begin
                    n_rem = DB'(div_t - {1'b0, r_dt2});
                    n_q   = {r_q[QB-2:0], 1'b1};
                end else begin
                    n_rem = div_t[DB-1:0];
                    n_q   = {r_q[QB-2:0], 1'b0};
                end
                n_cnt = r_cnt - 4'd1;
                n_sv   = n_q;
                n_sr2  = '0;
                n_sbit = 16'h4000;
            end
            gblr_pkg::S_SQRT: begin
                if ({1'b0, r_sv} >= sq_t) begin
                    n_sv  = QB'({1'b0, r_sv} - sq_t);
                    n_sr2 = (r_sr2 >> 1) + r_sbit;
                end else begin
                    n_sr2 = r_sr2 >> 1;
                end
                n_sbit = r_sbit >> 2;
                n_v8   = n_sr2[7:0];
                n_ch   = gblr_pkg::CH_DEPTH;
            end
            gblr_pkg::S_BLEND: begin
                unique case (r_ch)
                    gblr_pkg::CH_DEPTH: n_pd = bl_res;
                    gblr_pkg::CH_RED:   n_pr = bl_res[7:0];
                    gblr_pkg::CH_GREEN: n_pg = bl_res[7:0];
                    gblr_pkg::CH_BLUE:  n_pb = bl_res[7:0];
                    default:            n_pd = bl_res;
                endcase
                n_ch = gblr_pkg::t_chan'(r_ch + 2'd1);
            end
            gblr_pkg::S_OUT: begin
                if (out_acc) begin
                    if (r_err > 0) begin
                        if (r_xmaj) n_y = r_negy ? r_y - 1'b1 : r_y + 1'b1;
                        else        n_x = r_negx ? r_x - 1'b1 : r_x + 1'b1;
                        n_err = r_err + $signed({2'b00, minor, 1'b0})
                                      - $signed({2'b00, major, 1'b0});
                    end else begin
                        n_err = r_err + $signed({2'b00, minor, 1'b0});
                    end
                    if (r_xmaj) n_x = r_negx ? r_x - 1'b1 : r_x + 1'b1;
                    else        n_y = r_negy ? r_y - 1'b1 : r_y + 1'b1;
                    n_steps = r_steps - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gblr_pkg::S_IDLE;
            r_steps <= '0;
            r_cnt   <= '0;
            r_ch    <= gblr_pkg::CH_DEPTH;
        end else begin
            r_state <= n_state;
            r_steps <= n_steps;
            r_cnt   <= n_cnt;
            r_ch    <= n_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sx <= i_start_x;  r_sy <= i_start_y;
            r_sd <= i_start_depth; r_ed <= i_end_depth;
            r_sr <= i_start_red;   r_sg <= i_start_green; r_sb <= i_start_blue;
            r_er <= i_end_red;     r_eg <= i_end_green;   r_eb <= i_end_blue;
            r_adx  <= a_adx;
            r_ady  <= a_ady;
            r_xmaj <= a_xmaj;
            r_negx <= a_dx[CB];
            r_negy <= a_dy[CB];
        end
        r_x <= n_x; r_y <= n_y; r_err <= n_err;
        r_dt2 <= n_dt2; r_rem <= n_rem; r_q <= n_q;
        r_sv <= n_sv; r_sr2 <= n_sr2; r_sbit <= n_sbit; r_v8 <= n_v8;
        r_pd <= n_pd; r_pr <= n_pr; r_pg <= n_pg; r_pb <= n_pb;
    end

    assign o_in_ready    = (r_state == gblr_pkg::S_IDLE);
    assign o_out_valid   = (r_state == gblr_pkg::S_OUT);
    assign o_pixel_x     = r_x;
    assign o_pixel_y     = r_y;
    assign o_pixel_depth = r_pd;
    assign o_pixel_red   = r_pr;
    assign o_pixel_green = r_pg;
    assign o_pixel_blue  = r_pb;
    assign o_last_pixel  = (r_steps == CB'(1));

`ifndef SYNTHESIS
    a_busy_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid) else $error("ready while pixel pending");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_last_pixel |=> o_in_ready) else $error("no idle after last pixel");
    a_steps_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_steps != '0) else $error("pixel with no steps left");
`endif

endmodule
